[hdl/ter_pkg.sv]
// Shared types and constants for the transport event recorder.
package ter_pkg;

    localparam logic [31:0] OVERFLOW_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_START        = 3'd0,
        CMD_CONTINUE     = 3'd1,
        CMD_STOP         = 3'd2,
        CMD_RESET_TEMPO  = 3'd3,
        CMD_TAKE_EVENT   = 3'd4,
        CMD_TAKE_RECORD  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_START    = 2'd1,
        EV_CONTINUE = 2'd2,
        EV_STOP     = 2'd3
    } t_event;

    // One log record as held in the ring
    typedef struct packed {
        t_event      ev;
        logic [31:0] time_us;
        logic        running;
        logic        rearm;
        logic        stopped;
        logic        kept;
    } t_rec;

    // Control from the state logic to the log memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        t_rec wr_data;
    } t_ram_ctl;

    // Per-transaction status produced by the state logic
    typedef struct packed {
        t_event      pending;
        logic        rec_valid;
        logic [31:0] overflow;
        logic        running;
        logic        kept;
    } t_result;

endpackage

[hdl/transport_event_recorder.sv]
// Top level of the transport event recorder: handshakes, input and result registers.
//
// Usage
//   Command channel: i_in_valid / o_in_stall with command, timestamp, interval
//   flag and last pulse time. A transaction is taken on a rising edge with
//   i_in_valid high and o_in_stall low.
//   Result channel: o_out_valid / i_out_stall, one result per command, in order.
//   Configuration: i_cfg_valid / o_cfg_ready carry the activity timeout in
//   microseconds; o_cfg_ready is always high. Write it only while idle.
//   Path: a taken command passes the input register, then the result register.
//   Throughput: one command per cycle while i_out_stall is low; the flags, ring
//   pointers and overflow count update together as a command leaves the input
//   register and the log memory read is registered into the result stage.
//   Reset (synchronous, active low): flags, pending event, ring pointers,
//   overflow count and timeout clear; log contents are left as they are and
//   are never read before being written.
//   Stall: while the result register is held by i_out_stall, the command in
//   the input register waits and o_in_stall rises; one command is buffered.
//   Record fields read as zero when no record was popped.
module transport_event_recorder import ter_pkg::*; #(
    parameter int LOG_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_timestamp_us,
    input  logic        i_intervals_seen,
    input  logic [31:0] i_last_pulse_us,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_pending_event_out,
    output logic        o_record_valid,
    output logic [1:0]  o_record_event,
    output logic [31:0] o_record_time_us,
    output logic        o_record_running,
    output logic        o_record_rearm,
    output logic        o_record_stop_latched,
    output logic        o_record_kept_clock,
    output logic [31:0] o_overflow_total,
    output logic        o_is_running,
    output logic        o_kept_clock_now
);

    localparam int AW = $clog2(LOG_DEPTH);

    // configuration
    logic [31:0]   r_timeout_us;

    // input register
    logic          r_in_valid;
    logic [2:0]    r_command;
    logic [31:0]   r_timestamp_us;
    logic          r_intervals_seen;
    logic [31:0]   r_last_pulse_us;

    // result register
    logic          r_out_valid;
    t_result       r_result;

    logic          w_accept;
    logic          w_advance;
    logic          w_fire;
    t_ram_ctl      w_ram_ctl;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_result       w_result;
    t_rec          w_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_us <= i_cfg_data;
        end
    end

    // Result register frees up when empty or being taken this cycle
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command        <= i_command;
            r_timestamp_us   <= i_timestamp_us;
            r_intervals_seen <= i_intervals_seen;
            r_last_pulse_us  <= i_last_pulse_us;
        end
    end

    ter_ctrl #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_command        (r_command),
        .i_timestamp_us   (r_timestamp_us),
        .i_intervals_seen (r_intervals_seen),
        .i_last_pulse_us  (r_last_pulse_us),
        .i_timeout_us     (r_timeout_us),
        .o_ram_ctl        (w_ram_ctl),
        .o_waddr          (w_waddr),
        .o_raddr          (w_raddr),
        .o_result         (w_result)
    );

    // Read data register of the ring doubles as the record part of the result
    ter_log_ram #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_ram_ctl),
        .i_waddr   (w_waddr),
        .i_raddr   (w_raddr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_pending_event_out   = r_result.pending;
    assign o_record_valid        = r_result.rec_valid;
    assign o_record_event        = r_result.rec_valid ? w_rd_data.ev : EV_NONE;
    assign o_record_time_us      = r_result.rec_valid ? w_rd_data.time_us : '0;
    assign o_record_running      = r_result.rec_valid && w_rd_data.running;
    assign o_record_rearm        = r_result.rec_valid && w_rd_data.rearm;
    assign o_record_stop_latched = r_result.rec_valid && w_rd_data.stopped;
    assign o_record_kept_clock   = r_result.rec_valid && w_rd_data.kept;
    assign o_overflow_total      = r_result.overflow;
    assign o_is_running          = r_result.running;
    assign o_kept_clock_now      = r_result.kept;

endmodule

[hdl/ter_log_ram.sv]
// Log ring storage: one write port, one registered read port.
module ter_log_ram import ter_pkg::*; #(
    parameter int  LOG_DEPTH = 8,
    localparam int AW        = $clog2(LOG_DEPTH)
) (
    input  logic          i_clk,
    input  t_ram_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rd_data
);

    t_rec r_mem [LOG_DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/ter_ctrl.sv]
// Transport flags, pending-event latch, ring pointers and overflow count.
module ter_ctrl import ter_pkg::*; #(
    parameter int  LOG_DEPTH = 8,
    localparam int AW        = $clog2(LOG_DEPTH),
    localparam int FW        = $clog2(LOG_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [2:0]    i_command,
    input  logic [31:0]   i_timestamp_us,
    input  logic          i_intervals_seen,
    input  logic [31:0]   i_last_pulse_us,
    input  logic [31:0]   i_timeout_us,
    output t_ram_ctl      o_ram_ctl,
    output logic [AW-1:0] o_waddr,
    output logic [AW-1:0] o_raddr,
    output t_result       o_result
);

    localparam logic [AW-1:0] LAST_IDX = AW'(LOG_DEPTH - 1);
    localparam logic [FW-1:0] FULL     = FW'(LOG_DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0]   r_overflow, n_overflow;
    logic          r_running, n_running;
    logic          r_rearm, n_rearm;
    logic          r_stop, n_stop;
    t_event        r_pending, n_pending;

    logic          w_kept;
    logic          w_push;
    t_event        w_push_ev;
    logic [31:0]   w_age;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] ptr);
        f_next = (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
    endfunction

    assign w_age  = i_timestamp_us - i_last_pulse_us;
    assign w_kept = i_intervals_seen && (i_last_pulse_us != '0) &&
                    (i_timeout_us != '0) && (w_age <= i_timeout_us);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_overflow = r_overflow;
        n_running  = r_running;
        n_rearm    = r_rearm;
        n_stop     = r_stop;
        n_pending  = r_pending;
        w_push     = 1'b0;
        w_push_ev  = EV_NONE;

        o_ram_ctl           = '0;
        o_result            = '0;

        case (t_cmd'(i_command))
            CMD_START, CMD_CONTINUE: begin
                w_push_ev = (t_cmd'(i_command) == CMD_START) ? EV_START : EV_CONTINUE;
                w_push    = 1'b1;
                n_running = 1'b1;
                n_rearm   = 1'b0;
                n_stop    = 1'b0;
                n_pending = w_push_ev;
                o_result.kept = w_kept;
            end
            CMD_STOP: begin
                w_push_ev = EV_STOP;
                w_push    = 1'b1;
                n_running = 1'b0;
                n_rearm   = 1'b1;
                n_stop    = 1'b1;
                n_pending = EV_STOP;
            end
            CMD_RESET_TEMPO: begin
                n_running = 1'b0;
                n_rearm   = 1'b0;
                n_stop    = 1'b0;
                n_pending = EV_NONE;
            end
            CMD_TAKE_EVENT: begin
                o_result.pending = r_pending;
                n_pending        = EV_NONE;
            end
            CMD_TAKE_RECORD: begin
                if (r_fill != '0) begin
                    o_ram_ctl.rd_en    = i_fire;
                    o_result.rec_valid = 1'b1;
                    n_head             = f_next(r_head);
                    n_fill             = r_fill - FW'(1);
                end
            end
            default: begin
            end
        endcase

        // Append; a full ring drops its oldest record first
        if (w_push) begin
            if (r_fill == FULL) begin
                n_head = f_next(r_head);
                if (r_overflow != OVERFLOW_MAX) begin
                    n_overflow = r_overflow + 32'd1;
                end
            end else begin
                n_fill = r_fill + FW'(1);
            end
            n_tail = f_next(r_tail);
            o_ram_ctl.wr_en                = i_fire;
            o_ram_ctl.wr_data.ev           = w_push_ev;
            o_ram_ctl.wr_data.time_us      = i_timestamp_us;
            o_ram_ctl.wr_data.running      = n_running;
            o_ram_ctl.wr_data.rearm        = n_rearm;
            o_ram_ctl.wr_data.stopped      = n_stop;
            o_ram_ctl.wr_data.kept         = (w_push_ev == EV_STOP) ? 1'b0 : w_kept;
        end

        o_result.overflow = n_overflow;
        o_result.running  = n_running;
    end

    assign o_waddr = r_tail;
    assign o_raddr = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_overflow <= '0;
            r_running  <= 1'b0;
            r_rearm    <= 1'b0;
            r_stop     <= 1'b0;
            r_pending  <= EV_NONE;
        end else if (i_fire) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_overflow <= n_overflow;
            r_running  <= n_running;
            r_rearm    <= n_rearm;
            r_stop     <= n_stop;
            r_pending  <= n_pending;
        end
    end

endmodule

[test/ter_checker.sv]
// Checker for the transport event recorder: predicts each result and compares it.
module ter_checker import ter_pkg::*; #(
    parameter int LOG_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_timestamp_us,
    input  logic        i_intervals_seen,
    input  logic [31:0] i_last_pulse_us,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_pending_event_out,
    input  logic        i_record_valid,
    input  logic [1:0]  i_record_event,
    input  logic [31:0] i_record_time_us,
    input  logic        i_record_running,
    input  logic        i_record_rearm,
    input  logic        i_record_stop_latched,
    input  logic        i_record_kept_clock,
    input  logic [31:0] i_overflow_total,
    input  logic        i_is_running,
    input  logic        i_kept_clock_now,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        t_event      pending;
        logic        rec_valid;
        t_rec        rec;
        logic [31:0] overflow;
        logic        running;
        logic        kept;
    } t_outcome;

    t_rec        ring [LOG_DEPTH];
    int          head;
    int          tail;
    int          fill;
    logic [31:0] overflow_count;
    logic        running;
    logic        rearm;
    logic        stopped;
    t_event      pending;
    logic [31:0] timeout_us;
    t_outcome    outcomes_due [$];
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    // flags are captured after the command has updated them
    task automatic log_event(input t_event ev, input logic [31:0] now, input logic kept);
        if (fill >= LOG_DEPTH) begin
            head = (head + 1) % LOG_DEPTH;
            fill--;
            if (overflow_count != OVERFLOW_MAX)
                overflow_count++;
        end
        ring[tail].ev           = ev;
        ring[tail].time_us      = now;
        ring[tail].running      = running;
        ring[tail].rearm        = rearm;
        ring[tail].stopped      = stopped;
        ring[tail].kept         = kept;
        tail = (tail + 1) % LOG_DEPTH;
        fill++;
    endtask

    task automatic apply_command(input logic [2:0] cmd, input logic [31:0] now,
                                 input logic seen, input logic [31:0] last);
        t_outcome    res;
        logic [31:0] age;
        t_event      ev;
        res = '0;
        age = now - last;
        case (cmd)
            CMD_START, CMD_CONTINUE: begin
                ev = (cmd == CMD_START) ? EV_START : EV_CONTINUE;
                res.kept = seen && (last != 0) && (timeout_us != 0) && (age <= timeout_us);
                rearm        = 1'b0;
                running      = 1'b1;
                stopped      = 1'b0;
                pending      = ev;
                log_event(ev, now, res.kept);
            end
            CMD_STOP: begin
                rearm        = 1'b1;
                running      = 1'b0;
                stopped      = 1'b1;
                pending      = EV_STOP;
                log_event(EV_STOP, now, 1'b0);
            end
            CMD_RESET_TEMPO: begin
                rearm        = 1'b0;
                running      = 1'b0;
                stopped      = 1'b0;
                pending      = EV_NONE;
            end
            CMD_TAKE_EVENT: begin
                res.pending = pending;
                pending     = EV_NONE;
            end
            CMD_TAKE_RECORD: begin
                if (fill != 0) begin
                    res.rec_valid = 1'b1;
                    res.rec       = ring[head];
                    head = (head + 1) % LOG_DEPTH;
                    fill--;
                end
            end
            default: ;
        endcase
        res.overflow = overflow_count;
        res.running  = running;
        outcomes_due.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            head           = 0;
            tail           = 0;
            fill           = 0;
            overflow_count = '0;
            running        = 1'b0;
            rearm          = 1'b0;
            stopped        = 1'b0;
            pending        = EV_NONE;
            timeout_us     = '0;
            outcomes_due.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                timeout_us = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected", $time);
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("pending_event_out", want.pending, i_pending_event_out);
                    check_field("record_valid", want.rec_valid, i_record_valid);
                    check_field("record_event", want.rec.ev, i_record_event);
                    check_field("record_time_us", want.rec.time_us, i_record_time_us);
                    check_field("record_running", want.rec.running, i_record_running);
                    check_field("record_rearm", want.rec.rearm, i_record_rearm);
                    check_field("record_stop_latched", want.rec.stopped,
                                i_record_stop_latched);
                    check_field("record_kept_clock", want.rec.kept, i_record_kept_clock);
                    check_field("overflow_total", want.overflow, i_overflow_total);
                    check_field("is_running", want.running, i_is_running);
                    check_field("kept_clock_now", want.kept, i_kept_clock_now);
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_command(i_command, i_timestamp_us, i_intervals_seen, i_last_pulse_us);
            o_outstanding <= outcomes_due.size();
        end
    end

endmodule

[test/tb_transport_event_recorder.sv]
// Testbench top for the transport event recorder: stimulus, back-pressure and verdict.
module tb_transport_event_recorder;
    import ter_pkg::*;

    localparam int LOG_DEPTH    = 8;
    localparam int CYCLE_LIMIT  = 200000;   // watchdog limit for a whole run
    localparam int SEGMENT_LEN  = 400;      // random transactions per segment
    localparam int SEGMENTS     = 4;

    // codes outside the defined command set; the recorder must ignore them
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  command    = CMD_TAKE_EVENT;
    logic [31:0] stamp_us   = '0;
    logic        seen       = 1'b0;
    logic [31:0] pulse_us   = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  pending_ev;
    logic        rec_valid;
    logic [1:0]  rec_event;
    logic [31:0] rec_time_us;
    logic        rec_running;
    logic        rec_rearm;
    logic        rec_stop;
    logic        rec_kept;
    logic [31:0] overflow_total;
    logic        is_running;
    logic        kept_now;

    int          mismatches;
    int          outstanding;
    int          cycles     = 0;
    int          tx_idle_pct = 0;    // chance of a gap before each command transaction
    int          rx_idle_pct = 0;    // chance of stalling the result channel per cycle
    int          arm_pct     = 55;   // share of start/continue/stop in random traffic
    logic [31:0] clock_us    = 32'd1000;
    logic [31:0] timeout_now = '0;   // mirror of the programmed timeout, for stimulus shaping

    always #5 clk = ~clk;

    transport_event_recorder #(.LOG_DEPTH(LOG_DEPTH)) dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_command            (command),
        .i_timestamp_us       (stamp_us),
        .i_intervals_seen     (seen),
        .i_last_pulse_us      (pulse_us),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_pending_event_out  (pending_ev),
        .o_record_valid       (rec_valid),
        .o_record_event       (rec_event),
        .o_record_time_us     (rec_time_us),
        .o_record_running     (rec_running),
        .o_record_rearm       (rec_rearm),
        .o_record_stop_latched(rec_stop),
        .o_record_kept_clock  (rec_kept),
        .o_overflow_total     (overflow_total),
        .o_is_running         (is_running),
        .o_kept_clock_now     (kept_now)
    );

    ter_checker #(.LOG_DEPTH(LOG_DEPTH)) recorder_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_command            (command),
        .i_timestamp_us       (stamp_us),
        .i_intervals_seen     (seen),
        .i_last_pulse_us      (pulse_us),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_pending_event_out  (pending_ev),
        .i_record_valid       (rec_valid),
        .i_record_event       (rec_event),
        .i_record_time_us     (rec_time_us),
        .i_record_running     (rec_running),
        .i_record_rearm       (rec_rearm),
        .i_record_stop_latched(rec_stop),
        .i_record_kept_clock  (rec_kept),
        .i_overflow_total     (overflow_total),
        .i_is_running         (is_running),
        .i_kept_clock_now     (kept_now),
        .o_mismatches         (mismatches),
        .o_outstanding        (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_transport_event_recorder: errors");
            $finish;
        end
    end

    // Result-side back-pressure, redrawn every cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // One command transaction. Optional idle gap first; valid is only lowered in
    // the gap, so back-to-back transactions keep it high without a glitch.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] now,
                                input logic flag, input logic [31:0] last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        stamp_us <= now;
        seen     <= flag;
        pulse_us <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drain: every command gives one result, so once nothing is outstanding the
    // recorder is idle; a short pause follows.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        wait_idle();
        cfg_valid   <= 1'b1;
        cfg_data    <= value;
        timeout_now  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random command with a running clock. The last pulse time is placed around
    // the timeout window edge often enough to exercise both keep outcomes,
    // including windows that straddle the 32-bit wrap.
    task automatic send_random();
        int          pick;
        int          mode;
        logic [2:0]  cmd;
        logic [31:0] last;
        if ($urandom_range(0, 19) == 0)
            clock_us = $urandom;
        else
            clock_us = clock_us + $urandom_range(0, 3000);

        pick = $urandom_range(0, 99);
        if (pick < arm_pct / 2)
            cmd = CMD_START;
        else if (pick < arm_pct * 3 / 4)
            cmd = CMD_CONTINUE;
        else if (pick < arm_pct)
            cmd = CMD_STOP;
        else if (pick < arm_pct + 5)
            cmd = CMD_RESET_TEMPO;
        else if (pick < arm_pct + 20)
            cmd = CMD_TAKE_EVENT;
        else if (pick < 97)
            cmd = CMD_TAKE_RECORD;
        else
            cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

        mode = $urandom_range(0, 9);
        case (mode)
            0:       last = '0;
            1:       last = clock_us - timeout_now;
            2:       last = clock_us - timeout_now - 32'd1;
            3, 4, 5: last = clock_us - $urandom_range(0, 2000);
            6, 7:    last = $urandom;
            8:       last = clock_us;
            default: last = clock_us - 32'($urandom % (longint'(timeout_now) + 1));
        endcase

        send_command(cmd, clock_us, ($urandom_range(0, 99) < 85), last);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 26;
        rx_idle_pct = 66;
        write_timeout(32'd1000);

        // Directed: empty takes, ignored codes, keep-window edges, wrap, stop,
        // tempo reset and a ring overrun.
        send_command(CMD_TAKE_RECORD, 32'd0, 1'b0, 32'd0);                 // empty ring
        send_command(CMD_TAKE_EVENT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);  // nothing latched
        send_command(CMD_SPARE_LO, 32'd123, 1'b1, 32'd100);
        send_command(CMD_SPARE_HI, 32'd456, 1'b0, 32'd400);
        send_command(CMD_START, 32'd5000, 1'b1, 32'd4500);                 // inside window
        send_command(CMD_CONTINUE, 32'd6000, 1'b1, 32'd5000);              // on the edge
        send_command(CMD_START, 32'd6001, 1'b1, 32'd5000);                 // one past
        send_command(CMD_CONTINUE, 32'd6100, 1'b0, 32'd6000);              // no interval yet
        send_command(CMD_START, 32'd6200, 1'b1, 32'd0);                    // no pulse
        send_command(CMD_CONTINUE, 32'd100, 1'b1, 32'hFFFF_FF00);          // across wrap
        send_command(CMD_STOP, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_command(CMD_TAKE_EVENT, 32'd7000, 1'b0, 32'd0);               // stop
        send_command(CMD_TAKE_EVENT, 32'd7001, 1'b0, 32'd0);               // now empty
        send_command(CMD_START, 32'd0, 1'b1, 32'hFFFF_FFFF);               // fills the ring
        send_command(CMD_RESET_TEMPO, 32'd7100, 1'b1, 32'd7000);
        send_command(CMD_TAKE_EVENT, 32'd7200, 1'b0, 32'd0);               // cleared by reset
        send_command(CMD_STOP, 32'd7300, 1'b1, 32'd7250);                  // overwrites oldest
        send_command(CMD_CONTINUE, 32'd7400, 1'b1, 32'd7350);              // and again
        send_command(CMD_TAKE_RECORD, 32'd7500, 1'b0, 32'd0);
        send_command(CMD_TAKE_RECORD, 32'd7600, 1'b0, 32'd0);
        send_command(CMD_TAKE_RECORD, 32'd7700, 1'b0, 32'd0);

        // Random segments: each has its own timeout; only the first two add back-pressure.
        // Arm-heavy segments overrun the ring; take-heavy ones drain it empty.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin tx_idle_pct = 26; rx_idle_pct = 66; end
                1: begin tx_idle_pct = 66; rx_idle_pct = 26; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            arm_pct = (seg % 2 == 0) ? 55 : 25;
            case (seg)
                0:       write_timeout($urandom_range(500, 5000));
                1:       write_timeout(32'd0);
                2:       write_timeout(32'hFFFF_FFFF);
                default: write_timeout(32'd1);
            endcase
            for (int n = 0; n < SEGMENT_LEN; n++)
                send_random();
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb_transport_event_recorder: clean");
        else
            $display("tb_transport_event_recorder: errors");
        $finish;
    end

endmodule

[sim.f]
hdl/ter_pkg.sv
hdl/ter_log_ram.sv
hdl/ter_ctrl.sv
hdl/transport_event_recorder.sv
test/ter_checker.sv
test/tb_transport_event_recorder.sv
